@@ hw/rtl/dkdlc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkdlc_pkg
// Types, register indexes and reset constants for the debounced key dimmer
// level control.
// ----------------------------------------------------------------------------
package dkdlc_pkg;

  localparam int unsigned CfgDataW = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned LevelW   = 8;
  localparam int unsigned StepW    = 6;
  localparam int unsigned BtnW     = 4;
  localparam int unsigned ChanW    = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACCEPT_COUNT = 3'd0,
    CFG_FIRST_REPEAT = 3'd1,
    CFG_FAST_REPEAT  = 3'd2,
    CFG_LEVEL_STEP   = 3'd3,
    CFG_MAX_LEVEL    = 3'd4
  } cfg_idx_t;

  localparam logic REQ_SCAN = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  localparam logic [ChanW-1:0] CHAN_ONE = 2'd1;
  localparam logic [ChanW-1:0] CHAN_TWO = 2'd2;

  localparam logic [7:0]       RST_ACCEPT_COUNT = 8'd5;
  localparam logic [7:0]       RST_FIRST_REPEAT = 8'd50;
  localparam logic [7:0]       RST_FAST_REPEAT  = 8'd10;
  localparam logic [StepW-1:0] RST_LEVEL_STEP   = 6'd5;
  localparam logic [7:0]       RST_MAX_LEVEL    = 8'd250;

  typedef struct packed {
    logic [7:0]        accept_count;
    logic [7:0]        first_repeat_limit;
    logic [7:0]        fast_repeat_limit;
    logic [StepW-1:0]  level_step;
    logic [LevelW-1:0] max_level;
  } dkdlc_cfg_t;

  typedef struct packed {
    logic              req_type;
    logic [BtnW-1:0]   buttons_n;
    logic              load_channel;
    logic [LevelW-1:0] load_value;
  } dkdlc_in_t;

  typedef struct packed {
    logic [LevelW-1:0] duty_a;
    logic [LevelW-1:0] duty_b;
    logic [ChanW-1:0]  selected_channel;
    logic [BtnW-1:0]   key_event;
    logic              save_request;
    logic              save_address;
    logic [LevelW-1:0] save_value;
  } dkdlc_out_t;

endpackage

@@ hw/rtl/debounced_key_dimmer_level_control.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_key_dimmer_level_control
// Debounced four-button dimmer control with auto-repeat for two PWM channels.
//
//   channel | ports                        | moves
//   --------+------------------------------+---------------------------------
//   in      | in_valid, in_stall, in_data  | scan tick or level load request
//   out     | out_valid, out_stall, out_data | levels, key event, save request
//   cfg     | cfg_we, cfg_idx, cfg_wdata   | register write, no read-back
//
// A request is held in the input register, then its result lands in the
// output register, which drives out_valid and out_data; one request per
// cycle is sustained while out_stall is low.
// The output register holds a result while out_stall is high; in_stall rises
// only when both registers are occupied and the output is stalled.
// rst_n is synchronous; it clears valids and state, registers take defaults.
// ----------------------------------------------------------------------------
module debounced_key_dimmer_level_control
  import dkdlc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dkdlc_in_t           in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dkdlc_out_t          out_data,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  dkdlc_cfg_t cfg;
  dkdlc_in_t  in_data_r;
  logic       in_vld_r;
  dkdlc_out_t res;
  dkdlc_out_t out_data_r;
  logic       out_vld_r;
  logic       advance;
  logic       fire;
  logic       in_acc;

  assign advance  = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;
  assign in_acc   = in_valid && !in_stall;

  dkdlc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dkdlc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .req   (in_data_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (advance || !in_vld_r) begin
      in_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/dkdlc_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkdlc_cfg
// Configuration register file: debounce counts, step size and level ceiling.
// ----------------------------------------------------------------------------
module dkdlc_cfg
  import dkdlc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output dkdlc_cfg_t          cfg
);

  dkdlc_cfg_t cfg_r;
  dkdlc_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ACCEPT_COUNT: cfg_nxt.accept_count       = cfg_wdata;
        CFG_FIRST_REPEAT: cfg_nxt.first_repeat_limit = cfg_wdata;
        CFG_FAST_REPEAT:  cfg_nxt.fast_repeat_limit  = cfg_wdata;
        CFG_LEVEL_STEP:   cfg_nxt.level_step         = cfg_wdata[StepW-1:0];
        CFG_MAX_LEVEL:    cfg_nxt.max_level          = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.accept_count       <= RST_ACCEPT_COUNT;
      cfg_r.first_repeat_limit <= RST_FIRST_REPEAT;
      cfg_r.fast_repeat_limit  <= RST_FAST_REPEAT;
      cfg_r.level_step         <= RST_LEVEL_STEP;
      cfg_r.max_level          <= RST_MAX_LEVEL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/dkdlc_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dkdlc_core
// Press counter, auto-repeat limit, channel levels and selection; computes
// the result of one request and commits the state when it fires.
// ----------------------------------------------------------------------------
module dkdlc_core
  import dkdlc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  dkdlc_in_t  req,
  input  dkdlc_cfg_t cfg,
  output dkdlc_out_t res
);

  logic [7:0]        press_cnt_r,  press_cnt_nxt;
  logic [7:0]        rpt_limit_r,  rpt_limit_nxt;
  logic [LevelW-1:0] level_a_r,    level_a_nxt;
  logic [LevelW-1:0] level_b_r,    level_b_nxt;
  logic [ChanW-1:0]  chan_r,       chan_nxt;
  logic              dirty_r,      dirty_nxt;

  logic [BtnW-1:0]   pressed;
  logic [7:0]        cnt_inc;
  logic [BtnW-1:0]   key;
  logic              sel_b;
  logic [LevelW-1:0] sel_lvl;
  logic [LevelW-1:0] new_lvl;
  logic              lvl_wr;
  logic [LevelW:0]   up_sum;
  logic [LevelW-1:0] load_lvl;

  always_comb begin
    pressed  = ~req.buttons_n;
    cnt_inc  = press_cnt_r + 8'd1;
    sel_b    = (chan_r == CHAN_TWO);
    sel_lvl  = sel_b ? level_b_r : level_a_r;
    up_sum   = {1'b0, sel_lvl} + {{(LevelW+1-StepW){1'b0}}, cfg.level_step};
    load_lvl = (req.load_value > cfg.max_level) ? cfg.max_level : req.load_value;

    press_cnt_nxt = press_cnt_r;
    rpt_limit_nxt = rpt_limit_r;
    level_a_nxt   = level_a_r;
    level_b_nxt   = level_b_r;
    chan_nxt      = chan_r;
    dirty_nxt     = dirty_r;
    key           = '0;
    new_lvl       = sel_lvl;
    lvl_wr        = 1'b0;

    res.save_request = 1'b0;
    res.save_address = 1'b0;
    res.save_value   = '0;

    if (req.req_type == REQ_LOAD) begin
      if (req.load_channel) level_b_nxt = load_lvl;
      else                  level_a_nxt = load_lvl;
    end else if (pressed != '0) begin
      press_cnt_nxt = cnt_inc;
      if (cnt_inc == cfg.accept_count) key = pressed;
      if (cnt_inc == rpt_limit_r) begin
        press_cnt_nxt = '0;
        rpt_limit_nxt = cfg.fast_repeat_limit;
      end
      // key priority: down, up, right, left
      if (key[0]) begin
        if (sel_lvl >= {{(LevelW-StepW){1'b0}}, cfg.level_step}) begin
          new_lvl   = sel_lvl - {{(LevelW-StepW){1'b0}}, cfg.level_step};
          lvl_wr    = 1'b1;
          dirty_nxt = 1'b1;
        end
      end else if (key[1]) begin
        if (up_sum <= {1'b0, cfg.max_level}) begin
          new_lvl   = up_sum[LevelW-1:0];
          lvl_wr    = 1'b1;
          dirty_nxt = 1'b1;
        end
      end else if (key[2]) begin
        chan_nxt = CHAN_TWO;
      end else if (key[3]) begin
        chan_nxt = CHAN_ONE;
      end
      if (lvl_wr) begin
        if (sel_b) level_b_nxt = new_lvl;
        else       level_a_nxt = new_lvl;
      end
    end else begin
      if (dirty_r) begin
        res.save_request = 1'b1;
        res.save_address = sel_b;
        res.save_value   = sel_lvl;
        dirty_nxt        = 1'b0;
      end
      rpt_limit_nxt = cfg.first_repeat_limit;
      press_cnt_nxt = '0;
    end

    res.duty_a           = level_a_nxt;
    res.duty_b           = level_b_nxt;
    res.selected_channel = chan_nxt;
    res.key_event        = key;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_cnt_r <= '0;
      rpt_limit_r <= RST_FIRST_REPEAT;
      level_a_r   <= '0;
      level_b_r   <= '0;
      chan_r      <= CHAN_ONE;
      dirty_r     <= 1'b0;
    end else if (fire) begin
      press_cnt_r <= press_cnt_nxt;
      rpt_limit_r <= rpt_limit_nxt;
      level_a_r   <= level_a_nxt;
      level_b_r   <= level_b_nxt;
      chan_r      <= chan_nxt;
      dirty_r     <= dirty_nxt;
    end
  end

endmodule

@@ sim/debounced_key_dimmer_level_control_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_key_dimmer_level_control_tb
// Self-checking bench for the two-channel dimmer key control. Scan ticks and
// level loads go in with random gaps while the result side stalls at random.
// A scoreboard class tracks the debounce counter, the auto-repeat limit, both
// channel levels, the selected channel and the save flag, and checks every
// result field. It runs a directed opening, then random button sequences
// under several register settings, including the extremes.
// ----------------------------------------------------------------------------
module debounced_key_dimmer_level_control_tb;
  import dkdlc_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int          MaxReports = 10;

  localparam logic [BtnW-1:0] KEYS_NONE = 4'b0000;
  localparam logic [BtnW-1:0] KEYS_DEC  = 4'b0001;
  localparam logic [BtnW-1:0] KEYS_INC  = 4'b0010;
  localparam logic [BtnW-1:0] KEYS_CH2  = 4'b0100;
  localparam logic [BtnW-1:0] KEYS_CH1  = 4'b1000;
  localparam logic [BtnW-1:0] KEYS_ALL  = 4'b1111;

  class dimmer_scoreboard;
    logic [7:0]        accept_count;
    logic [7:0]        first_limit;
    logic [7:0]        fast_limit;
    logic [StepW-1:0]  level_step;
    logic [LevelW-1:0] max_level;
    logic [7:0]        press_count;
    logic [7:0]        repeat_limit;
    logic [LevelW-1:0] levels [2];
    logic [ChanW-1:0]  channel;
    logic              dirty;
    dkdlc_out_t        pending_outputs [$];
    int                mismatches;

    function new();
      accept_count = RST_ACCEPT_COUNT;
      first_limit  = RST_FIRST_REPEAT;
      fast_limit   = RST_FAST_REPEAT;
      level_step   = RST_LEVEL_STEP;
      max_level    = RST_MAX_LEVEL;
      press_count  = '0;
      repeat_limit = RST_FIRST_REPEAT;
      levels[0]    = '0;
      levels[1]    = '0;
      channel      = CHAN_ONE;
      dirty        = 1'b0;
      mismatches   = 0;
    endfunction

    function void set_register(cfg_idx_t idx, logic [CfgDataW-1:0] value);
      case (idx)
        CFG_ACCEPT_COUNT: accept_count = value;
        CFG_FIRST_REPEAT: first_limit = value;
        CFG_FAST_REPEAT:  fast_limit = value;
        CFG_LEVEL_STEP:   level_step = value[StepW-1:0];
        CFG_MAX_LEVEL:    max_level = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_outputs.size();
    endfunction

    function void step_level(logic [BtnW-1:0] keys);
      int slot;
      int lvl;
      int stp;
      slot = (channel == CHAN_TWO) ? 1 : 0;
      lvl  = levels[slot];
      stp  = level_step;
      if ((keys & KEYS_DEC) != 0) begin
        if (lvl >= stp) begin
          levels[slot] = LevelW'(lvl - stp);
          dirty = 1'b1;
        end
      end else if ((keys & KEYS_INC) != 0) begin
        if (lvl + stp <= max_level) begin
          levels[slot] = LevelW'(lvl + stp);
          dirty = 1'b1;
        end
      end else if ((keys & KEYS_CH2) != 0) begin
        if (channel < CHAN_TWO) channel = CHAN_TWO;
      end else if ((keys & KEYS_CH1) != 0) begin
        if (channel > CHAN_ONE) channel = CHAN_ONE;
      end
    endfunction

    function void note_request(dkdlc_in_t req);
      dkdlc_out_t result;
      logic [BtnW-1:0] pressed;
      logic [BtnW-1:0] keys;
      int slot;
      result = '0;
      keys   = KEYS_NONE;
      if (req.req_type == REQ_LOAD) begin
        levels[req.load_channel] = (req.load_value > max_level) ? max_level : req.load_value;
      end else begin
        pressed = ~req.buttons_n;
        if (pressed != KEYS_NONE) begin
          press_count = press_count + 8'd1;
          if (press_count == accept_count) keys = pressed;
          if (press_count == repeat_limit) begin
            press_count  = '0;
            repeat_limit = fast_limit;
          end
          if (keys != KEYS_NONE) step_level(keys);
        end else begin
          if (dirty) begin
            slot = (channel == CHAN_TWO) ? 1 : 0;
            result.save_request = 1'b1;
            result.save_address = slot[0];
            result.save_value   = levels[slot];
            dirty = 1'b0;
          end
          repeat_limit = first_limit;
          press_count  = '0;
        end
      end
      result.duty_a           = levels[0];
      result.duty_b           = levels[1];
      result.selected_channel = channel;
      result.key_event        = keys;
      pending_outputs.push_back(result);
    endfunction

    function void check_result(dkdlc_out_t got);
      dkdlc_out_t want;
      if (pending_outputs.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) $display("unexpected result %h", got);
        return;
      end
      want = pending_outputs.pop_front();
      if (got.duty_a !== want.duty_a || got.duty_b !== want.duty_b ||
          got.selected_channel !== want.selected_channel ||
          got.key_event !== want.key_event ||
          got.save_request !== want.save_request ||
          got.save_address !== want.save_address ||
          got.save_value !== want.save_value) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("mismatch: expected a=%0d b=%0d sel=%0d key=%b save=%b/%0d/%0d",
                   want.duty_a, want.duty_b, want.selected_channel, want.key_event,
                   want.save_request, want.save_address, want.save_value);
          $display("          actual   a=%0d b=%0d sel=%0d key=%b save=%b/%0d/%0d",
                   got.duty_a, got.duty_b, got.selected_channel, got.key_event,
                   got.save_request, got.save_address, got.save_value);
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid;
  logic                in_stall;
  dkdlc_in_t           in_data;
  logic                out_valid;
  logic                out_stall;
  dkdlc_out_t          out_data;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  dimmer_scoreboard dimmer_sb;
  bit               quiet_mode = 1'b0;
  int               sent_count = 0;
  int unsigned      cycle_count = 0;

  debounced_key_dimmer_level_control dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic dkdlc_in_t scan_req(logic [BtnW-1:0] pressed);
    dkdlc_in_t req;
    req.req_type     = REQ_SCAN;
    req.buttons_n    = ~pressed;
    req.load_channel = 1'($urandom);
    req.load_value   = LevelW'($urandom);
    return req;
  endfunction

  function automatic dkdlc_in_t load_req(logic chan, logic [LevelW-1:0] value);
    dkdlc_in_t req;
    req.req_type     = REQ_LOAD;
    req.buttons_n    = BtnW'($urandom);
    req.load_channel = chan;
    req.load_value   = value;
    return req;
  endfunction

  task automatic send_request(dkdlc_in_t req);
    int gap;
    gap = quiet_mode ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    dimmer_sb.note_request(req);
    sent_count++;
  endtask

  task automatic hold_keys(logic [BtnW-1:0] pressed, int ticks);
    repeat (ticks) send_request(scan_req(pressed));
  endtask

  task automatic write_register(cfg_idx_t idx, logic [CfgDataW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    dimmer_sb.set_register(idx, value);
  endtask

  task automatic write_settings(logic [7:0] acc, logic [7:0] first, logic [7:0] fast,
                                logic [7:0] step, logic [7:0] maxl);
    in_valid <= 1'b0;
    while (dimmer_sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_register(CFG_ACCEPT_COUNT, acc);
    write_register(CFG_FIRST_REPEAT, first);
    write_register(CFG_FAST_REPEAT, fast);
    write_register(CFG_LEVEL_STEP, step);
    write_register(CFG_MAX_LEVEL, maxl);
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(int count);
    int target;
    int kind;
    int ticks;
    logic [BtnW-1:0] mask;
    target = sent_count + count;
    while (sent_count < target) begin
      if ($urandom_range(0, 7) == 0) quiet_mode = ~quiet_mode;
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        if ($urandom_range(0, 3) == 0) mask = BtnW'($urandom_range(1, 15));
        else mask = KEYS_DEC << $urandom_range(0, 3);
        ticks = $urandom_range(1, dimmer_sb.first_limit + 3 * dimmer_sb.fast_limit + 2);
        if (ticks > 200) ticks = 200;
        hold_keys(mask, ticks);
        hold_keys(KEYS_NONE, $urandom_range(1, 3));
      end else if (kind == 6) begin
        send_request(load_req(1'($urandom), LevelW'($urandom)));
      end else begin
        repeat ($urandom_range(1, 6)) send_request(scan_req(BtnW'($urandom)));
      end
    end
  endtask

  // result side: draw a stall per result, then take it
  initial begin
    int hold;
    out_stall <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      hold = quiet_mode ? 0 : $urandom_range(0, 9);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      dimmer_sb.check_result(out_data);
    end
  end

  initial begin
    dimmer_sb = new();
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= CFG_ACCEPT_COUNT;
    cfg_wdata <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: accept after five ticks, clamp a load
    send_request(load_req(1'b1, 8'd255));
    hold_keys(KEYS_INC, 6);
    hold_keys(KEYS_NONE, 1);

    // fire on the first tick, repeat every tick after the second
    write_settings(8'd1, 8'd2, 8'd1, 8'd50, 8'd255);
    send_request(load_req(1'b0, 8'd0));
    send_request(load_req(1'b1, 8'd255));
    hold_keys(KEYS_DEC, 1);
    hold_keys(KEYS_NONE, 1);
    hold_keys(KEYS_INC, 6);
    hold_keys(KEYS_NONE, 1);
    hold_keys(KEYS_CH2, 1);
    hold_keys(KEYS_NONE, 1);
    hold_keys(KEYS_INC, 1);
    hold_keys(KEYS_NONE, 1);
    hold_keys(KEYS_ALL, 1);
    hold_keys(KEYS_NONE, 1);
    hold_keys(KEYS_CH1, 1);
    hold_keys(KEYS_NONE, 1);
    send_request(load_req(1'b0, 8'd255));

    write_settings(8'd1, 8'd1, 8'd1, 8'd1, 8'd255);
    run_random(60);

    // zero counts match only after the counter wraps; zero step still marks dirty
    write_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd255);
    hold_keys(KEYS_DEC, 260);
    hold_keys(KEYS_NONE, 1);
    run_random(20);

    write_settings(8'd2, 8'd6, 8'd3, 8'd63, 8'd200);
    run_random(60);

    repeat (5) begin
      int acc;
      acc = $urandom_range(1, 6);
      write_settings(8'(acc), 8'(acc + $urandom_range(0, 20)), 8'($urandom_range(1, 12)),
                     8'($urandom_range(1, 50)),
                     8'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 60)
                                                    : $urandom_range(100, 255)));
      run_random(30);
    end

    in_valid <= 1'b0;
    while (dimmer_sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (dimmer_sb.mismatches == 0 && dimmer_sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
